// File: sv/tcow_pkg.sv
package tcow_pkg;

   localparam int GLYPH_W     = 8;
   localparam int GLYPH_H     = 11;
   localparam int GLYPH_COUNT = 11;
   localparam logic [3:0] COLON_GLYPH = 4'd10;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_LINE_PITCH   = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_FRAME_HEIGHT = 2'd3
   } csr_index_type;

   localparam logic FMT_8BIT  = 1'b0;
   localparam logic FMT_10BIT = 1'b1;

   // 8-bit packing colours.
   localparam logic [7:0] Y8_SET   = 8'hEB;
   localparam logic [7:0] Y8_CLEAR = 8'h10;
   localparam logic [7:0] C8       = 8'h80;
   localparam logic [7:0] K8       = 8'hEB;

   // 10-bit packing colours.
   localparam logic [9:0] Y10_SET   = 10'h3C0;
   localparam logic [9:0] Y10_CLEAR = 10'h040;
   localparam logic [9:0] C10       = 10'h200;
   localparam logic [9:0] K10       = 10'h3C0;

   typedef logic [3:0] digit_table_type [0:127];
   typedef logic [7:0] glyph_rom_type [0:GLYPH_COUNT-1][0:GLYPH_H-1];
   typedef logic [15:0][3:0] chars_type;

   function automatic digit_table_type make_tens_table();
      digit_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = 4'((i / 10) % 10);
      end
      return t;
   endfunction

   function automatic digit_table_type make_ones_table();
      digit_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = 4'(i % 10);
      end
      return t;
   endfunction

   localparam digit_table_type TENS_TABLE = make_tens_table();
   localparam digit_table_type ONES_TABLE = make_ones_table();

   // Bit n of a row is pixel column n, so bit 0 is the leftmost column.
   localparam glyph_rom_type GLYPH_ROM = '{
      '{8'h00, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h00},
      '{8'h00, 8'h08, 8'h0E, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h3E, 8'h00},
      '{8'h00, 8'h3C, 8'h42, 8'h42, 8'h40, 8'h20, 8'h18, 8'h04, 8'h02, 8'h7E, 8'h00},
      '{8'h00, 8'h3C, 8'h42, 8'h40, 8'h40, 8'h38, 8'h40, 8'h40, 8'h42, 8'h3C, 8'h00},
      '{8'h00, 8'h20, 8'h30, 8'h28, 8'h24, 8'h22, 8'h7E, 8'h20, 8'h20, 8'h20, 8'h00},
      '{8'h00, 8'h7C, 8'h04, 8'h04, 8'h04, 8'h3C, 8'h40, 8'h40, 8'h42, 8'h3C, 8'h00},
      '{8'h00, 8'h38, 8'h04, 8'h02, 8'h3E, 8'h42, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h00},
      '{8'h00, 8'h7E, 8'h40, 8'h20, 8'h20, 8'h10, 8'h10, 8'h08, 8'h08, 8'h08, 8'h00},
      '{8'h00, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h00},
      '{8'h00, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h42, 8'h7C, 8'h40, 8'h20, 8'h1C, 8'h00},
      '{8'h00, 8'h00, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00, 8'h08, 8'h08, 8'h00, 8'h00}
   };

   // Out-of-range glyph or row codes read as an empty row.
   function automatic logic [7:0] glyph_row(input logic [3:0] ch, input logic [3:0] gy);
      logic [7:0] row;
      row = 8'h00;
      if (ch < 4'(GLYPH_COUNT) && gy < 4'(GLYPH_H)) begin
         row = GLYPH_ROM[ch][gy];
      end
      return row;
   endfunction

endpackage

// File: sv/timecode_overlay_word_generator_top.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   line, word index, old word, timecode
// rsp_      out        rsp_valid / rsp_ready   byte address, new word, write flag
// csr_      in         csr_write_enable        csr_index, csr_write_data
//
// Four register stages: decode, pixel column, glyph lookup, word merge.
// One word enters per clock while the output is not stalled.
// Each stage holds until the one after it has room, so bubbles are squeezed out
// and a stalled output loses nothing. Reset clears the valid bits and the
// configuration registers.
module timecode_overlay_word_generator_top
   import tcow_pkg::*;
#(
   parameter int GLYPH_SCALE = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_line,
   input  logic [8:0]  req_word_index,
   input  logic [31:0] req_old_word,
   input  logic [6:0]  req_hours,
   input  logic [6:0]  req_minutes,
   input  logic [6:0]  req_seconds,
   input  logic [6:0]  req_frames,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [21:0] rsp_byte_address,
   output logic [31:0] rsp_new_word,
   output logic        rsp_write_flag,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int OVL_W     = GLYPH_COUNT * GLYPH_W * GLYPH_SCALE;
   localparam int OVL_H     = GLYPH_H * GLYPH_SCALE;
   localparam int RECIP_SH  = 14;
   localparam int RECIP     = ((1 << RECIP_SH) + GLYPH_SCALE - 1) / GLYPH_SCALE;
   localparam int LANES     = 4;

   // Configuration registers.
   logic        pixel_format_ff;
   logic [15:0] line_pitch_ff;
   logic [13:0] frame_width_ff;
   logic [12:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= 1'b0;
         line_pitch_ff   <= '0;
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_write_data[0];
            CSR_LINE_PITCH:   line_pitch_ff   <= csr_write_data;
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[13:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   // Stage valids and enables: a stage loads when it is empty or drains.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4       = !v4_ff || rsp_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- Stage 1: decode ----------------
   chars_type   chars1_in;
   logic [18:0] q_prod;
   logic [7:0]  q3;
   logic [8:0]  rem3;
   logic [9:0]  base1_in;
   logic [1:0]  k1_in;
   logic [20:0] gy_prod;
   logic        rowok1_in;
   logic [21:0] addr1_in;

   always_comb begin
      chars1_in      = '0;
      chars1_in[0]   = TENS_TABLE[req_hours];
      chars1_in[1]   = ONES_TABLE[req_hours];
      chars1_in[2]   = COLON_GLYPH;
      chars1_in[3]   = TENS_TABLE[req_minutes];
      chars1_in[4]   = ONES_TABLE[req_minutes];
      chars1_in[5]   = COLON_GLYPH;
      chars1_in[6]   = TENS_TABLE[req_seconds];
      chars1_in[7]   = ONES_TABLE[req_seconds];
      chars1_in[8]   = COLON_GLYPH;
      chars1_in[9]   = TENS_TABLE[req_frames];
      chars1_in[10]  = ONES_TABLE[req_frames];
   end

   // Word index divided by three through a reciprocal, exact for nine bits.
   assign q_prod = 19'(req_word_index) * 19'd683;
   assign q3     = q_prod[18:11];
   assign rem3   = req_word_index - 9'(q3) * 9'd3;

   always_comb begin
      if (pixel_format_ff == FMT_8BIT) begin
         base1_in = {q3, 2'b00};
         k1_in    = rem3[1:0];
      end else begin
         base1_in = {1'b0, req_word_index[8:1], 1'b0};
         k1_in    = {1'b0, req_word_index[0]};
      end
   end

   assign gy_prod   = 21'(req_line) * 21'(RECIP);
   assign rowok1_in = (7'(req_line) < 7'(OVL_H)) && (13'(req_line) < frame_height_ff);
   assign addr1_in  = 22'(line_pitch_ff) * 22'(req_line) + {11'b0, req_word_index, 2'b00};

   chars_type   chars1_ff;
   logic [9:0]  base1_ff;
   logic [1:0]  k1_ff;
   logic [3:0]  gy1_ff;
   logic        rowok1_ff;
   logic [21:0] addr1_ff;
   logic [31:0] old1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         chars1_ff <= chars1_in;
         base1_ff  <= base1_in;
         k1_ff     <= k1_in;
         gy1_ff    <= gy_prod[RECIP_SH +: 4];
         rowok1_ff <= rowok1_in;
         addr1_ff  <= addr1_in;
         old1_ff   <= req_old_word;
      end
   end

   // ---------------- Stage 2: pixel columns ----------------
   logic [LANES-1:0]      ok2_in;
   logic [LANES-1:0][3:0] col2_in;
   logic [LANES-1:0][2:0] gx2_in;

   always_comb begin
      logic [9:0]  x;
      logic [24:0] xs_prod;
      for (int p = 0; p < LANES; p++) begin
         x          = base1_ff + 10'(p);
         xs_prod    = 25'(x) * 25'(RECIP);
         ok2_in[p]  = rowok1_ff && (x < 10'(OVL_W)) && (14'(x) < frame_width_ff);
         col2_in[p] = xs_prod[RECIP_SH + 3 +: 4];
         gx2_in[p]  = xs_prod[RECIP_SH +: 3];
      end
   end

   chars_type             chars2_ff;
   logic [LANES-1:0]      ok2_ff;
   logic [LANES-1:0][3:0] col2_ff;
   logic [LANES-1:0][2:0] gx2_ff;
   logic [3:0]            gy2_ff;
   logic [1:0]            k2_ff;
   logic [21:0]           addr2_ff;
   logic [31:0]           old2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         chars2_ff <= chars1_ff;
         ok2_ff    <= ok2_in;
         col2_ff   <= col2_in;
         gx2_ff    <= gx2_in;
         gy2_ff    <= gy1_ff;
         k2_ff     <= k1_ff;
         addr2_ff  <= addr1_ff;
         old2_ff   <= old1_ff;
      end
   end

   // ---------------- Stage 3: glyph lookup ----------------
   logic [LANES-1:0] lit3_in;

   always_comb begin
      logic [7:0] row;
      for (int p = 0; p < LANES; p++) begin
         row        = glyph_row(chars2_ff[col2_ff[p]], gy2_ff);
         lit3_in[p] = row[gx2_ff[p]];
      end
   end

   logic [LANES-1:0] ok3_ff;
   logic [LANES-1:0] lit3_ff;
   logic [1:0]       k3_ff;
   logic [21:0]      addr3_ff;
   logic [31:0]      old3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         ok3_ff   <= ok2_ff;
         lit3_ff  <= lit3_in;
         k3_ff    <= k2_ff;
         addr3_ff <= addr2_ff;
         old3_ff  <= old2_ff;
      end
   end

   // ---------------- Stage 4: word merge ----------------
   logic [31:0] word4_in;
   logic        wr4_in;

   always_comb begin
      logic [7:0] y8 [LANES];
      logic [9:0] y10 [2];
      for (int p = 0; p < LANES; p++) begin
         y8[p] = lit3_ff[p] ? Y8_SET : Y8_CLEAR;
      end
      for (int p = 0; p < 2; p++) begin
         y10[p] = lit3_ff[p] ? Y10_SET : Y10_CLEAR;
      end
      word4_in = old3_ff;
      wr4_in   = 1'b0;
      if (pixel_format_ff == FMT_8BIT) begin
         case (k3_ff)
            2'd0: begin
               if (ok3_ff[0]) begin
                  word4_in = {K8, C8, y8[0], C8};
                  wr4_in   = 1'b1;
               end
            end
            2'd1: begin
               if (ok3_ff[1]) begin
                  word4_in[15:0] = {K8, y8[1]};
                  wr4_in         = 1'b1;
               end
               if (ok3_ff[2]) begin
                  word4_in[31:16] = {y8[2], C8};
                  wr4_in          = 1'b1;
               end
            end
            default: begin
               if (ok3_ff[2]) begin
                  word4_in[15:0] = {K8, C8};
                  wr4_in         = 1'b1;
               end
               if (ok3_ff[3]) begin
                  word4_in[31:16] = {K8, y8[3]};
                  wr4_in          = 1'b1;
               end
            end
         endcase
      end else if (k3_ff[0] == 1'b0) begin
         if (ok3_ff[0]) begin
            word4_in = {C10, y10[0], C10, 2'b00};
            wr4_in   = 1'b1;
         end
      end else begin
         if (ok3_ff[0]) begin
            word4_in[11:0] = {K10, 2'b00};
            wr4_in         = 1'b1;
         end
         // The second pixel also clears the two lowest bits of the word.
         if (ok3_ff[1]) begin
            word4_in = {K10, y10[1], word4_in[11:2], 2'b00};
            wr4_in   = 1'b1;
         end
      end
   end

   logic [21:0] addr4_ff;
   logic [31:0] word4_ff;
   logic        wr4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         addr4_ff <= addr3_ff;
         word4_ff <= word4_in;
         wr4_ff   <= wr4_in;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_byte_address = addr4_ff;
   assign rsp_new_word     = word4_ff;
   assign rsp_write_flag   = wr4_ff;

endmodule

// File: test/timecode_overlay_word_generator_top_test.sv
`timescale 1ns / 1ps

module timecode_overlay_word_generator_top_test;
   import tcow_pkg::*;

   localparam int SCALE          = 4;
   localparam int OVERLAY_W      = 88 * SCALE;
   localparam int OVERLAY_H      = 11 * SCALE;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RX_HOLD_CYCLES = 64;

   localparam logic [3:0] COLON_CODE = 4'd10;
   localparam logic [7:0] LUMA8_ON   = 8'hEB;
   localparam logic [7:0] LUMA8_OFF  = 8'h10;
   localparam logic [7:0] CHROMA8    = 8'h80;
   localparam logic [7:0] KEY8       = 8'hEB;
   localparam logic [9:0] LUMA10_ON  = 10'h3C0;
   localparam logic [9:0] LUMA10_OFF = 10'h040;
   localparam logic [9:0] CHROMA10   = 10'h200;
   localparam logic [9:0] KEY10      = 10'h3C0;

   // Digits 0 to 9 and the colon, eleven rows each; bit n of a row is column n.
   localparam logic [0:10][0:10][7:0] FONT_BITS = {
      8'h00, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h00,
      8'h00, 8'h08, 8'h0E, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h3E, 8'h00,
      8'h00, 8'h3C, 8'h42, 8'h42, 8'h40, 8'h20, 8'h18, 8'h04, 8'h02, 8'h7E, 8'h00,
      8'h00, 8'h3C, 8'h42, 8'h40, 8'h40, 8'h38, 8'h40, 8'h40, 8'h42, 8'h3C, 8'h00,
      8'h00, 8'h20, 8'h30, 8'h28, 8'h24, 8'h22, 8'h7E, 8'h20, 8'h20, 8'h20, 8'h00,
      8'h00, 8'h7C, 8'h04, 8'h04, 8'h04, 8'h3C, 8'h40, 8'h40, 8'h42, 8'h3C, 8'h00,
      8'h00, 8'h38, 8'h04, 8'h02, 8'h3E, 8'h42, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h00,
      8'h00, 8'h7E, 8'h40, 8'h20, 8'h20, 8'h10, 8'h10, 8'h08, 8'h08, 8'h08, 8'h00,
      8'h00, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h3C, 8'h00,
      8'h00, 8'h3C, 8'h42, 8'h42, 8'h42, 8'h42, 8'h7C, 8'h40, 8'h20, 8'h1C, 8'h00,
      8'h00, 8'h00, 8'h08, 8'h08, 8'h00, 8'h00, 8'h00, 8'h08, 8'h08, 8'h00, 8'h00
   };

   typedef logic [10:0][3:0] glyph_codes_type;

   typedef struct packed {
      logic [21:0] byte_address;
      logic [31:0] new_word;
      logic        write_flag;
   } overlay_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [5:0]  req_line;
   logic [8:0]  req_word_index;
   logic [31:0] req_old_word;
   logic [6:0]  req_hours;
   logic [6:0]  req_minutes;
   logic [6:0]  req_seconds;
   logic [6:0]  req_frames;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [21:0] rsp_byte_address;
   logic [31:0] rsp_new_word;
   logic        rsp_write_flag;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   // Register copies used by the predictor.
   logic        fmt_cfg;
   logic [15:0] pitch_cfg;
   logic [13:0] width_cfg;
   logic [12:0] height_cfg;

   overlay_word_type expected_words[$];
   overlay_word_type oldest_word;
   int          error_count;
   int          idle_cycles;
   bit          tx_gaps;
   bit          rx_stalls;
   bit          rx_hold_request;

   timecode_overlay_word_generator_top #(
      .GLYPH_SCALE (SCALE)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line         (req_line),
      .req_word_index   (req_word_index),
      .req_old_word     (req_old_word),
      .req_hours        (req_hours),
      .req_minutes      (req_minutes),
      .req_seconds      (req_seconds),
      .req_frames       (req_frames),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_address (rsp_byte_address),
      .rsp_new_word     (rsp_new_word),
      .rsp_write_flag   (rsp_write_flag),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit pixel_drawn(input int x, input int ln, input glyph_codes_type glyphs,
                                      output bit lit);
      int c;
      int gx;
      int gy;
      lit = 1'b0;
      if (x >= OVERLAY_W || x >= int'(width_cfg) || ln >= OVERLAY_H || ln >= int'(height_cfg))
         return 1'b0;
      c  = x / (8 * SCALE);
      gx = (x / SCALE) % 8;
      gy = ln / SCALE;
      lit = FONT_BITS[glyphs[c]][gy][gx];
      return 1'b1;
   endfunction

   function automatic overlay_word_type predict_overlay_word(
      input logic [5:0] line, input logic [8:0] word_index, input logic [31:0] old_word,
      input logic [6:0] hours, input logic [6:0] minutes, input logic [6:0] seconds,
      input logic [6:0] frames);
      overlay_word_type r;
      glyph_codes_type  glyphs;
      logic [3:0][6:0] vals;
      logic [31:0]   w;
      logic [31:0]   addr;
      logic [7:0]    y0, y1, y2, y3;
      logic [9:0]    z0, z1;
      bit            v0, v1, v2, v3, l0, l1, l2, l3, wr;
      int            base, k, i;
      vals = {frames, seconds, minutes, hours};
      glyphs = '0;
      for (i = 0; i < 4; i++) begin
         glyphs[3 * i]     = 4'((vals[i] / 10) % 10);
         glyphs[3 * i + 1] = 4'(vals[i] % 10);
         if (i < 3)
            glyphs[3 * i + 2] = COLON_CODE;
      end
      w  = old_word;
      wr = 1'b0;
      if (fmt_cfg == FMT_8BIT) begin
         base = 4 * (int'(word_index) / 3);
         k    = int'(word_index) % 3;
         v0 = pixel_drawn(base,     int'(line), glyphs, l0);
         v1 = pixel_drawn(base + 1, int'(line), glyphs, l1);
         v2 = pixel_drawn(base + 2, int'(line), glyphs, l2);
         v3 = pixel_drawn(base + 3, int'(line), glyphs, l3);
         y0 = l0 ? LUMA8_ON : LUMA8_OFF;
         y1 = l1 ? LUMA8_ON : LUMA8_OFF;
         y2 = l2 ? LUMA8_ON : LUMA8_OFF;
         y3 = l3 ? LUMA8_ON : LUMA8_OFF;
         case (k)
            0: begin
               if (v0) begin
                  w = {KEY8, CHROMA8, y0, CHROMA8};
                  wr = 1'b1;
               end
            end
            1: begin
               if (v1) begin
                  w = {w[31:16], KEY8, y1};
                  wr = 1'b1;
               end
               if (v2) begin
                  w = {y2, CHROMA8, w[15:0]};
                  wr = 1'b1;
               end
            end
            default: begin
               if (v2) begin
                  w = {w[31:16], KEY8, CHROMA8};
                  wr = 1'b1;
               end
               if (v3) begin
                  w = {KEY8, y3, w[15:0]};
                  wr = 1'b1;
               end
            end
         endcase
      end else begin
         base = 2 * (int'(word_index) / 2);
         k    = int'(word_index) % 2;
         v0 = pixel_drawn(base,     int'(line), glyphs, l0);
         v1 = pixel_drawn(base + 1, int'(line), glyphs, l1);
         z0 = l0 ? LUMA10_ON : LUMA10_OFF;
         z1 = l1 ? LUMA10_ON : LUMA10_OFF;
         if (k == 0) begin
            if (v0) begin
               w = {CHROMA10, z0, CHROMA10, 2'b00};
               wr = 1'b1;
            end
         end else begin
            if (v0) begin
               w = {w[31:12], KEY10, 2'b00};
               wr = 1'b1;
            end
            // The second pixel also clears the two low bits of the word.
            if (v1) begin
               w = {KEY10, z1, w[11:2], 2'b00};
               wr = 1'b1;
            end
         end
      end
      addr = 32'(pitch_cfg) * 32'(line) + 32'(word_index) * 32'd4;
      r.byte_address = addr[21:0];
      r.new_word     = w;
      r.write_flag   = wr;
      return r;
   endfunction

   // Offers one word and waits for it to be taken; the caller lowers valid afterwards.
   task automatic send_word(input logic [5:0] line, input logic [8:0] word_index,
                            input logic [31:0] old_word, input logic [6:0] hours,
                            input logic [6:0] minutes, input logic [6:0] seconds,
                            input logic [6:0] frames);
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_line       <= line;
      req_word_index <= word_index;
      req_old_word   <= old_word;
      req_hours      <= hours;
      req_minutes    <= minutes;
      req_seconds    <= seconds;
      req_frames     <= frames;
      do
         @(posedge clock);
      while (!req_ready);
      expected_words.push_back(predict_overlay_word(line, word_index, old_word,
                                                    hours, minutes, seconds, frames));
   endtask

   task automatic send_random_word();
      logic [5:0] line;
      logic [8:0] word_index;
      logic [6:0] hours, minutes, seconds, frames;
      int         last_word;
      // Most words fall inside the overlay with proper timecode values.
      last_word  = (fmt_cfg == FMT_8BIT) ? 263 : 351;
      line       = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 43));
      word_index = ($urandom_range(0, 9) == 0) ? 9'($urandom)
                                               : 9'($urandom_range(0, last_word));
      hours   = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
      minutes = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
      seconds = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
      frames  = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 99));
      send_word(line, word_index, $urandom, hours, minutes, seconds, frames);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic program_overlay(input logic fmt, input logic [15:0] pitch,
                                  input logic [13:0] width, input logic [12:0] height);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PIXEL_FORMAT;
      csr_write_data   <= 16'(fmt);
      @(posedge clock);
      csr_index        <= CSR_LINE_PITCH;
      csr_write_data   <= pitch;
      @(posedge clock);
      csr_index        <= CSR_FRAME_WIDTH;
      csr_write_data   <= 16'(width);
      @(posedge clock);
      csr_index        <= CSR_FRAME_HEIGHT;
      csr_write_data   <= 16'(height);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fmt_cfg    = fmt;
      pitch_cfg  = pitch;
      width_cfg  = width;
      height_cfg = height;
   endtask

   // With every register at its reset value of zero nothing may be drawn.
   task automatic test_reset_defaults();
      send_word(6'd0, 9'd0, 32'h1234_5678, 7'd12, 7'd34, 7'd56, 7'd78);
      send_word(6'd43, 9'd263, 32'hFFFF_FFFF, 7'd99, 7'd99, 7'd99, 7'd99);
      wait_drained();
   endtask

   task automatic test_directed_8bit();
      program_overlay(FMT_8BIT, 16'hFFFF, 14'd8192, 13'd4096);
      send_word(6'd0, 9'd0, 32'h0000_0000, 7'd0, 7'd0, 7'd0, 7'd0);
      send_word(6'd4, 9'd1, 32'hFFFF_FFFF, 7'd12, 7'd34, 7'd56, 7'd78);
      send_word(6'd8, 9'd2, 32'h0000_0000, 7'd88, 7'd88, 7'd88, 7'd88);
      send_word(6'd24, 9'd50, 32'h5A5A_5A5A, 7'd23, 7'd59, 7'd59, 7'd29);
      send_word(6'd43, 9'd263, 32'hFFFF_FFFF, 7'd127, 7'd127, 7'd127, 7'd127);
      send_word(6'd20, 9'd264, 32'hDEAD_BEEF, 7'd45, 7'd67, 7'd89, 7'd10);
      send_word(6'd63, 9'd511, 32'hA5A5_A5A5, 7'd99, 7'd0, 7'd99, 7'd0);
      wait_drained();
   endtask

   task automatic test_directed_10bit();
      program_overlay(FMT_10BIT, 16'd7680, 14'd16383, 13'd8191);
      send_word(6'd0, 9'd0, 32'hFFFF_FFFF, 7'd0, 7'd0, 7'd0, 7'd0);
      send_word(6'd8, 9'd1, 32'hFFFF_FFFF, 7'd11, 7'd22, 7'd33, 7'd44);
      send_word(6'd12, 9'd100, 32'h0000_0000, 7'd98, 7'd76, 7'd54, 7'd32);
      send_word(6'd28, 9'd70, 32'h0F0F_0F0F, 7'd100, 7'd105, 7'd110, 7'd119);
      send_word(6'd43, 9'd351, 32'hFFFF_FFFF, 7'd99, 7'd99, 7'd99, 7'd99);
      send_word(6'd43, 9'd352, 32'h1357_9BDF, 7'd1, 7'd2, 7'd3, 7'd4);
      send_word(6'd63, 9'd511, 32'h8000_0001, 7'd127, 7'd0, 7'd127, 7'd0);
      wait_drained();
   endtask

   // A narrow frame splits a word between a drawn and a clipped pixel.
   task automatic test_clipping();
      program_overlay(FMT_8BIT, 16'd0, 14'd2, 13'd1);
      send_word(6'd0, 9'd1, 32'hFFFF_FFFF, 7'd88, 7'd88, 7'd88, 7'd88);
      send_word(6'd0, 9'd2, 32'hFFFF_FFFF, 7'd88, 7'd88, 7'd88, 7'd88);
      send_word(6'd1, 9'd0, 32'h0000_0000, 7'd88, 7'd88, 7'd88, 7'd88);
      program_overlay(FMT_10BIT, 16'd100, 14'd1, 13'd44);
      send_word(6'd0, 9'd1, 32'hFFFF_FFFF, 7'd0, 7'd0, 7'd0, 7'd0);
      send_word(6'd43, 9'd0, 32'hFFFF_FFFF, 7'd0, 7'd0, 7'd0, 7'd0);
      send_word(6'd44, 9'd0, 32'hFFFF_FFFF, 7'd0, 7'd0, 7'd0, 7'd0);
      wait_drained();
   endtask

   task automatic test_random_frames();
      logic [15:0] pitch;
      logic [13:0] width;
      logic [12:0] height;
      int          mode;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 3))
            0:       pitch = 16'h0000;
            1:       pitch = 16'hFFFF;
            default: pitch = 16'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0:       width = 14'($urandom);
            1:       width = 14'($urandom_range(340, 360));
            2:       width = 14'($urandom_range(0, 40));
            default: width = 14'($urandom_range(352, 8192));
         endcase
         case ($urandom_range(0, 4))
            0:       height = 13'($urandom);
            1:       height = 13'($urandom_range(0, 45));
            default: height = 13'($urandom_range(44, 4096));
         endcase
         program_overlay(1'($urandom), pitch, width, height);
         mode      = $urandom_range(0, 3);
         tx_gaps   = mode[0];
         rx_stalls = mode[1];
         repeat (100) send_random_word();
      end
      wait_drained();
   endtask

   // The receiver holds off while words keep coming, so the pipeline fills up.
   task automatic test_output_stall();
      program_overlay(FMT_8BIT, 16'd2880, 14'd1920, 13'd1080);
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      rx_hold_request = 1'b1;
      repeat (40) send_random_word();
      wait_drained();
   endtask

   task automatic test_steady_stream();
      program_overlay(FMT_10BIT, 16'd5120, 14'd1280, 13'd720);
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      repeat (60) send_random_word();
      wait_drained();
   endtask

   always begin
      @(posedge clock);
      if (rx_hold_request) begin
         rsp_ready <= 1'b0;
         repeat (RX_HOLD_CYCLES) @(posedge clock);
         rsp_ready <= 1'b1;
         rx_hold_request = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("word at address %h arrived with nothing expected", rsp_byte_address);
            error_count++;
         end else begin
            oldest_word = expected_words.pop_front();
            if (rsp_byte_address !== oldest_word.byte_address) begin
               $error("byte_address: expected %h, actual %h",
                      oldest_word.byte_address, rsp_byte_address);
               error_count++;
            end
            if (rsp_new_word !== oldest_word.new_word) begin
               $error("new_word: expected %h, actual %h", oldest_word.new_word, rsp_new_word);
               error_count++;
            end
            if (rsp_write_flag !== oldest_word.write_flag) begin
               $error("write_flag: expected %b, actual %b",
                      oldest_word.write_flag, rsp_write_flag);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timecode_overlay_word_generator_top_test failed");
         $finish;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_line         = '0;
      req_word_index   = '0;
      req_old_word     = '0;
      req_hours        = '0;
      req_minutes      = '0;
      req_seconds      = '0;
      req_frames       = '0;
      rsp_ready        = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PIXEL_FORMAT;
      csr_write_data   = '0;
      fmt_cfg          = FMT_8BIT;
      pitch_cfg        = '0;
      width_cfg        = '0;
      height_cfg       = '0;
      error_count      = 0;
      idle_cycles      = 0;
      tx_gaps          = 1'b0;
      rx_stalls        = 1'b0;
      rx_hold_request  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      test_directed_8bit();
      test_directed_10bit();
      test_clipping();
      test_random_frames();
      test_output_stall();
      test_steady_stream();

      // Let the pipeline run on to catch any stray word.
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("timecode_overlay_word_generator_top_test passed");
      end else begin
         $display("timecode_overlay_word_generator_top_test failed");
      end
      $finish;
   end

endmodule
